// ----- hdl/asbs_pkg.sv -----
package asbs_pkg;

  // Field widths.
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned FADE_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Quotient bits produced by the fade-step divider, one per cycle.
  localparam int unsigned DIV_STEPS = FADE_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BOOST_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_TICKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESTART_MODE = 2'd2;

  // Register reset values.
  localparam logic [LEVEL_W-1:0] BOOST_TICKS_RST = 8'd20;
  localparam logic [LEVEL_W-1:0] FADE_TICKS_RST  = 8'd35;
  localparam logic               RESTART_MODE_RST = 1'b0;

  // Startup boost phases.
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_START = 6'b000010,
    PH_BOOST = 6'b000100,
    PH_END   = 6'b001000,
    PH_FADE  = 6'b010000,
    PH_WAIT  = 6'b100000
  } phase_t;

  // Request handling sequencer.
  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_ADV  = 4'b0010,
    C_DIV  = 4'b0100,
    C_RAMP = 4'b1000
  } ctrl_t;

endpackage

// ----- hdl/asbs_div.sv -----
module asbs_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [asbs_pkg::FADE_W-1:0]          dividend,
  input  logic [asbs_pkg::LEVEL_W-1:0]         divisor,
  output logic                                 busy,
  output logic                                 done,
  output logic [asbs_pkg::FADE_W-1:0]          quotient
);

  logic [asbs_pkg::LEVEL_W-1:0]   rem;
  logic [asbs_pkg::FADE_W-1:0]    quo;
  logic [asbs_pkg::DIV_CNT_W-1:0] cnt;
  logic [asbs_pkg::LEVEL_W:0]     trial;
  logic                           fits;

  // One restoring step: shift in the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem, quo[asbs_pkg::FADE_W-1]};
    fits  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= asbs_pkg::DIV_CNT_W'(asbs_pkg::DIV_STEPS);
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        if (fits) begin
          rem <= asbs_pkg::LEVEL_W'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[asbs_pkg::LEVEL_W-1:0];
        end
        quo <= {quo[asbs_pkg::FADE_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == asbs_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ----- hdl/assist_startup_boost_sequencer.sv -----
// Startup boost sequencer for pedal assist.
// Each request on the input channel (in_valid/in_ready) is one control tick.
// While boost ticks is non-zero the block advances the idle, start, boost,
// end, fade and wait phases, then ramps the faded current, and returns
// exactly one result on the output channel (out_valid/out_ready): boost
// flag, fade flag, current. A tick is accepted, advances the phase, then
// ramps and loads the result register; the tick that enters the fade with a
// non-zero fade length first waits for the fade step from a divider
// giving one quotient bit per cycle. The input is not ready while a tick is
// in work, so a new tick is accepted only after the last one is loaded.
// The result register lets the next tick be accepted while a result waits;
// if the receiver stalls, that next tick is held before its result stage.
// Registers are written on the cfg channel (cfg_valid/cfg_ready, always
// ready), index 0 boost ticks, 1 fade ticks, 2 restart mode; the user must
// write them only while no tick is in work, as the block does not enforce
// it. Reset: 20, 35, 0; sequence idle; flags, timers, fade state cleared.
module assist_startup_boost_sequencer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [asbs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [asbs_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [asbs_pkg::LEVEL_W-1:0]          torque_level,
  input  logic [asbs_pkg::LEVEL_W-1:0]          torque_raw_level,
  input  logic [asbs_pkg::LEVEL_W-1:0]          cadence_rpm,
  input  logic [asbs_pkg::SPEED_W-1:0]          wheel_speed,
  input  logic                                  brake_on,
  input  logic [asbs_pkg::LEVEL_W-1:0]          target_current,
  input  logic [asbs_pkg::LEVEL_W-1:0]          seed_current,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  boost_active,
  output logic                                  fade_active,
  output logic [asbs_pkg::LEVEL_W-1:0]          current_out
);

  // Configuration registers.
  logic [asbs_pkg::LEVEL_W-1:0] boost_ticks;
  logic [asbs_pkg::LEVEL_W-1:0] fade_ticks;
  logic                         restart_mode;

  // Captured request.
  logic [asbs_pkg::LEVEL_W-1:0] torque;
  logic [asbs_pkg::LEVEL_W-1:0] raw;
  logic [asbs_pkg::LEVEL_W-1:0] cadence;
  logic [asbs_pkg::SPEED_W-1:0] speed;
  logic                         brake;
  logic [asbs_pkg::LEVEL_W-1:0] target;
  logic [asbs_pkg::LEVEL_W-1:0] seed;

  // Sequence state.
  asbs_pkg::ctrl_t              ctrl, ctrl_next;
  asbs_pkg::phase_t             phase, phase_next;
  logic [asbs_pkg::LEVEL_W-1:0] boost_timer, boost_timer_next;
  logic [asbs_pkg::LEVEL_W-1:0] fade_steps_left, fade_steps_left_next;
  logic [asbs_pkg::FADE_W-1:0]  fade_value, fade_value_next;
  logic [asbs_pkg::FADE_W-1:0]  fade_step, fade_step_next;
  logic                         boost_flag, boost_flag_next;
  logic                         fade_flag, fade_flag_next;

  // Working values.
  logic [asbs_pkg::LEVEL_W-1:0] timer_dec;
  logic [asbs_pkg::LEVEL_W-1:0] steps_dec;
  logic [asbs_pkg::FADE_W-1:0]  goal;
  logic                         load_out;
  logic                         div_start;
  logic                         div_busy;
  logic                         div_done;
  logic [asbs_pkg::FADE_W-1:0]  div_quotient;

  assign cfg_ready = 1'b1;
  assign in_ready  = (ctrl == asbs_pkg::C_IDLE);

  // Divider for the fade step.
  asbs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({seed, asbs_pkg::LEVEL_W'(0)}),
    .divisor  (fade_ticks),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Sequencer and phase update.
  always_comb begin
    ctrl_next            = ctrl;
    phase_next           = phase;
    boost_timer_next     = boost_timer;
    fade_steps_left_next = fade_steps_left;
    fade_value_next      = fade_value;
    fade_step_next       = fade_step;
    boost_flag_next      = boost_flag;
    fade_flag_next       = fade_flag;
    div_start            = 1'b0;
    load_out             = 1'b0;
    timer_dec = (boost_timer != '0) ? boost_timer - 1'b1 : boost_timer;
    steps_dec = (fade_steps_left != '0) ? fade_steps_left - 1'b1 : fade_steps_left;
    goal      = {target, asbs_pkg::LEVEL_W'(0)};

    unique case (ctrl)
      asbs_pkg::C_IDLE: begin
        if (in_valid) begin
          ctrl_next = asbs_pkg::C_ADV;
        end
      end
      asbs_pkg::C_ADV: begin
        ctrl_next = asbs_pkg::C_RAMP;
        if (boost_ticks != '0) begin
          unique case (phase)
            asbs_pkg::PH_IDLE: begin
              if (torque != '0 && !brake) begin
                phase_next = asbs_pkg::PH_START;
              end
            end
            asbs_pkg::PH_START: begin
              boost_flag_next  = 1'b1;
              boost_timer_next = boost_ticks;
              phase_next       = asbs_pkg::PH_BOOST;
            end
            asbs_pkg::PH_BOOST: begin
              boost_timer_next = timer_dec;
              if (torque == '0 || timer_dec == '0) begin
                phase_next = asbs_pkg::PH_END;
              end
            end
            asbs_pkg::PH_END: begin
              boost_flag_next      = 1'b0;
              fade_steps_left_next = fade_ticks;
              fade_value_next      = {seed, asbs_pkg::LEVEL_W'(0)};
              fade_flag_next       = 1'b1;
              phase_next           = asbs_pkg::PH_FADE;
              if (fade_ticks != '0) begin
                div_start = 1'b1;
                ctrl_next = asbs_pkg::C_DIV;
              end else begin
                fade_step_next = '0;
              end
            end
            asbs_pkg::PH_FADE: begin
              fade_steps_left_next = steps_dec;
              if (raw == '0 || cadence == '0 || steps_dec == '0) begin
                fade_flag_next       = 1'b0;
                fade_steps_left_next = '0;
                phase_next           = asbs_pkg::PH_WAIT;
              end
            end
            asbs_pkg::PH_WAIT: begin
              if (restart_mode == 1'b0) begin
                if (speed == '0 && raw == '0) begin
                  phase_next = asbs_pkg::PH_IDLE;
                end
              end else if (raw == '0 || cadence == '0) begin
                phase_next = asbs_pkg::PH_IDLE;
              end
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end
      end
      asbs_pkg::C_DIV: begin
        if (div_done) begin
          fade_step_next = div_quotient;
          ctrl_next      = asbs_pkg::C_RAMP;
        end
      end
      asbs_pkg::C_RAMP: begin
        // The fade ramp is committed together with the result.
        if (!out_valid || out_ready) begin
          load_out  = 1'b1;
          ctrl_next = asbs_pkg::C_IDLE;
          if (fade_flag) begin
            priority if (fade_value > goal) begin
              fade_value_next = fade_value - fade_step;
            end else if (fade_value < goal) begin
              fade_value_next = fade_value + fade_step;
            end
          end
        end
      end
      default: begin
        ctrl_next = asbs_pkg::C_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      boost_ticks  <= asbs_pkg::BOOST_TICKS_RST;
      fade_ticks   <= asbs_pkg::FADE_TICKS_RST;
      restart_mode <= asbs_pkg::RESTART_MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        asbs_pkg::REG_BOOST_TICKS:  boost_ticks  <= cfg_data;
        asbs_pkg::REG_FADE_TICKS:   fade_ticks   <= cfg_data;
        asbs_pkg::REG_RESTART_MODE: restart_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      torque  <= torque_level;
      raw     <= torque_raw_level;
      cadence <= cadence_rpm;
      speed   <= wheel_speed;
      brake   <= brake_on;
      target  <= target_current;
      seed    <= seed_current;
    end
  end

  // Sequence state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl            <= asbs_pkg::C_IDLE;
      phase           <= asbs_pkg::PH_IDLE;
      boost_timer     <= '0;
      fade_steps_left <= '0;
      fade_value      <= '0;
      fade_step       <= '0;
      boost_flag      <= 1'b0;
      fade_flag       <= 1'b0;
    end else begin
      ctrl            <= ctrl_next;
      phase           <= phase_next;
      boost_timer     <= boost_timer_next;
      fade_steps_left <= fade_steps_left_next;
      fade_value      <= fade_value_next;
      fade_step       <= fade_step_next;
      boost_flag      <= boost_flag_next;
      fade_flag       <= fade_flag_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      boost_active <= boost_flag;
      fade_active  <= fade_flag;
      current_out  <= fade_flag ? fade_value_next[asbs_pkg::FADE_W-1 -: asbs_pkg::LEVEL_W]
                                : target;
    end
  end

  // Boost and fade never overlap.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(boost_flag && fade_flag))
    else $error("boost and fade flags set together");

  // The boost flag tracks the boost and end phases.
  a_boost_phase: assert property (@(posedge clk) disable iff (rst)
    boost_flag == (phase == asbs_pkg::PH_BOOST || phase == asbs_pkg::PH_END))
    else $error("boost flag out of step with phase");

  // The fade flag tracks the fade phase.
  a_fade_phase: assert property (@(posedge clk) disable iff (rst)
    fade_flag == (phase == asbs_pkg::PH_FADE))
    else $error("fade flag out of step with phase");

  // The divider only runs while the sequencer waits for it.
  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    (div_busy || div_done) |-> (ctrl == asbs_pkg::C_DIV))
    else $error("divider active outside the divide step");

  // A result is loaded only into a free or draining result register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !load_out)
    else $error("result register overwritten");

endmodule
